// ===== hdl/snh_pkg.sv =====
// ----------------------------------------------------------------------------
// snh_pkg
// Types and constants shared by the scene node hit test engine.
// ----------------------------------------------------------------------------
package snh_pkg;

  localparam logic [15:0] ROOT_CLIP = 16'd32000;

  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_TOUCH  = 2'd1;
  localparam logic [1:0] KIND_CLIP   = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         node_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        width;
    logic [15:0]        height;
    logic               has_handler;
    logic [15:0]        handler_control;
    logic [15:0]        handler_data;
    logic               touch_down;
    logic [15:0]        touch_x;
    logic [15:0]        touch_y;
  } in_t;

  typedef struct packed {
    logic [7:0]         new_node_id;
    logic               fired;
    logic [7:0]         handler_node;
    logic [15:0]        out_control;
    logic [15:0]        out_data;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic               pending_flag;
    logic [15:0]        clip_left;
    logic [15:0]        clip_top;
    logic [15:0]        clip_right;
    logic [15:0]        clip_bottom;
  } out_t;

  typedef struct packed {
    logic        hvld;
    logic [15:0] hdata;
    logic [15:0] hctrl;
    logic [7:0]  parent;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [15:0] cl;
    logic [15:0] ct;
    logic [15:0] cr;
    logic [15:0] cb;
  } node_t;

  typedef struct packed {
    logic        reject;
    logic [15:0] xtl;
    logic [15:0] ytl;
    logic [15:0] nl;
    logic [15:0] nt;
    logic [15:0] nr;
    logic [15:0] nb;
    logic        hit;
    logic [15:0] rl;
    logic [15:0] rt;
    logic [15:0] rr;
    logic [15:0] rb;
  } geom_t;

endpackage

// ===== hdl/snh_node_mem.sv =====
// ----------------------------------------------------------------------------
// snh_node_mem
// Node table memory with per-entry valid bits, registered read port.
// ----------------------------------------------------------------------------
module snh_node_mem #(
  parameter int MAX_NODES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [7:0]         waddr_i,
  input  snh_pkg::node_t     wdata_i,
  input  logic [7:0]         raddr_i,
  output snh_pkg::node_t     rdata_o
);

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  snh_pkg::node_t       mem_q [MAX_NODES];
  logic [MAX_NODES-1:0] vld_q;
  snh_pkg::node_t       rd_q;
  logic                 rd_ok_q;
  logic                 rin_range;

  assign rin_range = ({1'b0, raddr_i} < 9'(MAX_NODES));

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i[IW-1:0]] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i[IW-1:0]] <= 1'b1;
      end
      rd_ok_q <= rin_range && vld_q[raddr_i[IW-1:0]];
    end
  end

  assign rdata_o = rd_ok_q ? rd_q : '0;

endmodule

// ===== hdl/snh_geom.sv =====
// ----------------------------------------------------------------------------
// snh_geom
// Shared add and compare unit: node placement, hit test, rectangle clip.
// ----------------------------------------------------------------------------
module snh_geom (
  input  snh_pkg::node_t node_i,
  input  snh_pkg::in_t   item_i,
  output snh_pkg::geom_t geom_o
);

  logic [15:0]        xtl, ytl, xbr, ybr;
  logic [15:0]        xtlp, ytlp, xbrp, ybrp;
  logic signed [16:0] sx, sy, sum_x, sum_y;
  logic [15:0]        l, t, r, b;

  always_comb begin
    xtl  = node_i.ox + item_i.pos_x;
    ytl  = node_i.oy + item_i.pos_y;
    xbr  = xtl + item_i.width;
    ybr  = ytl + item_i.height;
    xtlp = xtl[15] ? 16'd0 : xtl;
    ytlp = ytl[15] ? 16'd0 : ytl;
    xbrp = xbr[15] ? 16'd0 : xbr;
    ybrp = ybr[15] ? 16'd0 : ybr;

    geom_o.xtl    = xtl;
    geom_o.ytl    = ytl;
    geom_o.reject = ($signed({xtl[15], xtl}) > $signed({1'b0, node_i.cr})) ||
                    ($signed({ytl[15], ytl}) > $signed({1'b0, node_i.cb})) ||
                    ($signed({xbr[15], xbr}) < $signed({1'b0, node_i.cl})) ||
                    ($signed({ybr[15], ybr}) < $signed({1'b0, node_i.ct}));
    geom_o.nl = (xtlp > node_i.cl) ? xtlp : node_i.cl;
    geom_o.nt = (ytlp > node_i.ct) ? ytlp : node_i.ct;
    geom_o.nr = (xbrp < node_i.cr) ? xbrp : node_i.cr;
    geom_o.nb = (ybrp < node_i.cb) ? ybrp : node_i.cb;

    sx = $signed({item_i.touch_x[15], item_i.touch_x});
    sy = $signed({item_i.touch_y[15], item_i.touch_y});
    geom_o.hit = !((sx < $signed({1'b0, node_i.cl})) || (sx > $signed({1'b0, node_i.cr})) ||
                   (sy < $signed({1'b0, node_i.ct})) || (sy > $signed({1'b0, node_i.cb})));

    sum_x = $signed({node_i.ox[15], node_i.ox}) + $signed({item_i.pos_x[15], item_i.pos_x});
    sum_y = $signed({node_i.oy[15], node_i.oy}) + $signed({item_i.pos_y[15], item_i.pos_y});
    l = sum_x[16] ? 16'd0 : sum_x[15:0];
    t = sum_y[16] ? 16'd0 : sum_y[15:0];
    r = l + item_i.width;
    b = t + item_i.height;
    geom_o.rl = (l > node_i.cl) ? l : node_i.cl;
    geom_o.rt = (t > node_i.ct) ? t : node_i.ct;
    geom_o.rr = (r < node_i.cr) ? r : node_i.cr;
    geom_o.rb = (b < node_i.cb) ? b : node_i.cb;
  end

endmodule

// ===== hdl/scene_node_hit_test_engine.sv =====
// ----------------------------------------------------------------------------
// scene_node_hit_test_engine
// Node table with create, touch hit test, rectangle clip and pending query.
// ----------------------------------------------------------------------------
// in channel: in_valid_i / in_stall_o with one in_t beat per command.
// out channel: out_valid_o / out_stall_i with one out_t beat per result.
// a clip command on node 0 gives no result beat.
// one sequencer drives a single registered-read node memory and one shared
// add and compare unit; every table lookup passes through the fetch state.
// query: push. create: push when ids have run out, else create at the root
// and fetch then create below it. clip: fetch then clip. touch: finish when
// held or with no nodes, else a fetch per node scanned newest first and per
// parent step of the handler walk, up to about 255 * 257 lookups at worst.
// a new command is taken only while the sequencer is idle; a finished beat
// waits in the output register, so the next command can start meanwhile.
// if the output is stalled when a second result is ready, the sequencer
// holds it until the output register frees up.
// reset clears the node valid bits, the touch and capture state and the
// output valid flag; the table needs no clearing pass.
// ----------------------------------------------------------------------------
module scene_node_hit_test_engine #(
  parameter int MAX_NODES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  snh_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output snh_pkg::out_t out_data_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FETCH  = 3'd1;
  localparam logic [2:0] ST_CREATE = 3'd2;
  localparam logic [2:0] ST_CLIP   = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;
  localparam logic [2:0] ST_WALK   = 3'd5;
  localparam logic [2:0] ST_TFIN   = 3'd6;
  localparam logic [2:0] ST_PUSH   = 3'd7;

  logic [2:0]     state_q, state_d, ret_q, ret_d;
  snh_pkg::in_t   item_q, item_d;
  snh_pkg::out_t  res_q, res_d, out_q;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     next_id_q, next_id_d, next_eff;
  logic [31:0]    last_q, last_d;
  logic [7:0]     capt_q, capt_d;
  logic           active_q, active_d;
  logic [31:0]    words_q, words_d;
  logic           pend_q, pend_d;
  logic [7:0]     addr_q, addr_d, scan_q, scan_d;
  logic [8:0]     steps_q, steps_d;
  logic           root_q, root_d;
  logic           in_acc, push, exhausted, we;
  snh_pkg::node_t rdata, wdata, gnode, root_node;
  snh_pkg::geom_t geom;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign push       = (state_q == ST_PUSH) && (!out_valid_q || !out_stall_i);

  always_comb begin
    root_node    = '0;
    root_node.cr = snh_pkg::ROOT_CLIP;
    root_node.cb = snh_pkg::ROOT_CLIP;
  end

  assign gnode = root_q ? root_node : rdata;

  snh_geom u_geom (
    .node_i (gnode),
    .item_i (item_q),
    .geom_o (geom)
  );

  always_comb begin
    wdata        = '0;
    wdata.hvld   = item_q.has_handler;
    wdata.hdata  = item_q.handler_data;
    wdata.hctrl  = item_q.handler_control;
    wdata.parent = item_q.node_id;
    wdata.ox     = geom.xtl;
    wdata.oy     = geom.ytl;
    wdata.cl     = geom.nl;
    wdata.ct     = geom.nt;
    wdata.cr     = geom.nr;
    wdata.cb     = geom.nb;
  end

  assign we = (state_q == ST_CREATE) && !geom.reject;

  snh_node_mem #(
    .MAX_NODES (MAX_NODES)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (next_id_q),
    .wdata_i (wdata),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign next_eff  = (in_data_i.node_id == 8'd0) ? 8'd1 : next_id_q;
  assign exhausted = (next_eff == 8'd0) || ({1'b0, next_eff} >= 9'(MAX_NODES));

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    item_d    = item_q;
    res_d     = res_q;
    next_id_d = next_id_q;
    last_d    = last_q;
    capt_d    = capt_q;
    active_d  = active_q;
    words_d   = words_q;
    pend_d    = pend_q;
    addr_d    = addr_q;
    scan_d    = scan_q;
    steps_d   = steps_q;
    root_d    = root_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          item_d = in_data_i;
          res_d  = '0;
          root_d = 1'b0;
          case (in_data_i.kind)
            snh_pkg::KIND_CREATE: begin
              next_id_d = next_eff;
              if (exhausted) begin
                state_d = ST_PUSH;
              end else if (in_data_i.node_id == 8'd0) begin
                root_d  = 1'b1;
                state_d = ST_CREATE;
              end else begin
                addr_d  = in_data_i.node_id;
                ret_d   = ST_CREATE;
                state_d = ST_FETCH;
              end
            end
            snh_pkg::KIND_TOUCH: begin
              if (in_data_i.touch_down) begin
                if (last_q != 32'd0) begin
                  res_d.delta_x = in_data_i.touch_x - last_q[15:0];
                  res_d.delta_y = in_data_i.touch_y - last_q[31:16];
                end
                last_d = {in_data_i.touch_y, in_data_i.touch_x};
              end else begin
                last_d = 32'd0;
              end
              scan_d = next_id_q - 8'd1;
              addr_d = next_id_q - 8'd1;
              if (capt_q != 8'd0 || next_id_q == 8'd1) begin
                state_d = ST_TFIN;
              end else begin
                ret_d   = ST_SCAN;
                state_d = ST_FETCH;
              end
            end
            snh_pkg::KIND_CLIP: begin
              if (in_data_i.node_id != 8'd0) begin
                addr_d  = in_data_i.node_id;
                ret_d   = ST_CLIP;
                state_d = ST_FETCH;
              end
            end
            default: begin
              res_d.pending_flag = pend_q;
              pend_d  = 1'b0;
              state_d = ST_PUSH;
            end
          endcase
        end
      end
      ST_FETCH: begin
        state_d = ret_q;
      end
      ST_CREATE: begin
        if (!geom.reject) begin
          res_d.new_node_id = next_id_q;
          next_id_d         = next_id_q + 8'd1;
        end
        state_d = ST_PUSH;
      end
      ST_CLIP: begin
        res_d.clip_left   = geom.rl;
        res_d.clip_top    = geom.rt;
        res_d.clip_right  = geom.rr;
        res_d.clip_bottom = geom.rb;
        state_d = ST_PUSH;
      end
      ST_SCAN, ST_WALK: begin
        if (state_q == ST_SCAN && !geom.hit) begin
          scan_d = scan_q - 8'd1;
          addr_d = scan_q - 8'd1;
          state_d = (scan_q == 8'd1) ? ST_TFIN : ST_FETCH;
        end else if (rdata.hvld) begin
          capt_d   = addr_q;
          words_d  = {rdata.hdata, rdata.hctrl};
          active_d = 1'b1;
          state_d  = ST_TFIN;
        end else begin
          steps_d = (state_q == ST_SCAN) ? 9'd1 : steps_q + 9'd1;
          if ((state_q == ST_WALK && steps_q == 9'd256) || rdata.parent == 8'd0) begin
            scan_d  = scan_q - 8'd1;
            addr_d  = scan_q - 8'd1;
            ret_d   = ST_SCAN;
            state_d = (scan_q == 8'd1) ? ST_TFIN : ST_FETCH;
          end else begin
            addr_d  = rdata.parent;
            ret_d   = ST_WALK;
            state_d = ST_FETCH;
          end
        end
      end
      ST_TFIN: begin
        if (capt_q != 8'd0) begin
          res_d.fired        = 1'b1;
          res_d.handler_node = capt_q;
          res_d.out_control  = words_q[15:0];
          res_d.out_data     = words_q[31:16];
          pend_d             = 1'b1;
        end
        if (!item_q.touch_down) begin
          capt_d   = 8'd0;
          active_d = 1'b0;
          words_d  = 32'd0;
        end
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (push) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = push || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      out_valid_q <= 1'b0;
      next_id_q   <= 8'd1;
      last_q      <= 32'd0;
      capt_q      <= 8'd0;
      active_q    <= 1'b0;
      words_q     <= 32'd0;
      pend_q      <= 1'b0;
      steps_q     <= 9'd0;
      root_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
      next_id_q   <= next_id_d;
      last_q      <= last_d;
      capt_q      <= capt_d;
      active_q    <= active_d;
      words_q     <= words_d;
      pend_q      <= pend_d;
      steps_q     <= steps_d;
      root_q      <= root_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    addr_q <= addr_d;
    scan_q <= scan_d;
    if (push) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_capture_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q == (capt_q != 8'd0))
    else $error("capture flag and captured node disagree");

  a_push_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_valid_q)
    else $error("result lost on its way to the output register");

  a_query_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.kind == snh_pkg::KIND_QUERY) |=> !pend_q)
    else $error("pending flag not cleared by query");

  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (steps_q <= 9'd256 && steps_q != 9'd0))
    else $error("handler walk step count out of range");

endmodule

// ===== bench/scene_node_hit_test_engine_tb.sv =====
// ----------------------------------------------------------------------------
// scene_node_hit_test_engine_tb
// Self-checking bench for the scene node hit test engine. A behavioral copy
// of the node table predicts every result beat of the create, touch, clip and
// query commands. Directed cases, id exhaustion, output back-pressure and a
// long run of random command sequences are checked beat by beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scene_node_hit_test_engine_tb;

  localparam int NodeLimit = 256;
  localparam int IdleLimit = 1000000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  snh_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  snh_pkg::out_t out_data_o;

  scene_node_hit_test_engine #(
    .MAX_NODES(NodeLimit)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // node table copy
  int          org_x [256];
  int          org_y [256];
  int          clp_l [256];
  int          clp_t [256];
  int          clp_r [256];
  int          clp_b [256];
  bit          hnd_v [256];
  logic [15:0] hnd_c [256];
  logic [15:0] hnd_d [256];
  logic [7:0]  par_id[256];
  logic [7:0]  next_id;
  logic [15:0] last_x, last_y;
  logic [7:0]  cap_node;
  bit          cap_on;
  logic [15:0] cap_c, cap_d;
  bit          pending;

  snh_pkg::out_t result_q[$];
  int            mismatches = 0;
  int            sent = 0;
  int            hold_req = 0;
  bit            in_burst = 0;
  bit            out_burst = 0;

  function automatic int s16(input int v);
    logic signed [15:0] t;
    t = v[15:0];
    return int'(t);
  endfunction

  function automatic int imax(input int a, input int b);
    return a > b ? a : b;
  endfunction

  function automatic int imin(input int a, input int b);
    return a < b ? a : b;
  endfunction

  function automatic logic [7:0] create_node(input snh_pkg::in_t c);
    int px, py, l, t, r, b, x, y, xtl, ytl, xbr, ybr;
    logic [7:0] p, id;
    p = c.node_id;
    x = s16(int'(c.pos_x));
    y = s16(int'(c.pos_y));
    px = 0; py = 0; l = 0; t = 0;
    r = int'(snh_pkg::ROOT_CLIP); b = int'(snh_pkg::ROOT_CLIP);
    if (p == 0) next_id = 8'd1;
    if (next_id == 0 || int'(next_id) >= NodeLimit) return 8'd0;
    if (p != 0) begin
      px = org_x[p]; py = org_y[p];
      l = clp_l[p]; t = clp_t[p]; r = clp_r[p]; b = clp_b[p];
    end
    xtl = s16(px + x);
    ytl = s16(py + y);
    xbr = s16(px + x + int'(c.width));
    ybr = s16(py + y + int'(c.height));
    if (xtl > r || ytl > b || xbr < l || ybr < t) return 8'd0;
    id = next_id;
    org_x[id] = xtl;
    org_y[id] = ytl;
    clp_l[id] = imax(l, imax(xtl, 0));
    clp_t[id] = imax(t, imax(ytl, 0));
    clp_r[id] = imin(r, imax(xbr, 0));
    clp_b[id] = imin(b, imax(ybr, 0));
    hnd_v[id] = c.has_handler;
    hnd_c[id] = c.handler_control;
    hnd_d[id] = c.handler_data;
    par_id[id] = p;
    next_id = id + 8'd1;
    return id;
  endfunction

  function automatic void touch_event(input snh_pkg::in_t c, inout snh_pkg::out_t r);
    logic [15:0] dx, dy;
    logic [7:0] n, w;
    int sx, sy, steps;
    dx = '0; dy = '0;
    sx = s16(int'(c.touch_x));
    sy = s16(int'(c.touch_y));
    if (c.touch_down) begin
      if (last_x != 0 || last_y != 0) begin
        dx = c.touch_x - last_x;
        dy = c.touch_y - last_y;
      end
      last_x = c.touch_x; last_y = c.touch_y;
    end else begin
      last_x = '0; last_y = '0;
    end
    n = next_id - 8'd1;
    while (n != 0 && cap_node == 0) begin
      if (!(sx < clp_l[n] || sx > clp_r[n] || sy < clp_t[n] || sy > clp_b[n])) begin
        w = n;
        steps = 0;
        while (w != 0 && !hnd_v[w]) begin
          steps++;
          if (steps > 256) begin
            w = 0;
            break;
          end
          w = par_id[w];
        end
        cap_node = w;
      end
      n--;
    end
    if (cap_node != 0) begin
      if (!cap_on) begin
        cap_c = hnd_c[cap_node];
        cap_d = hnd_d[cap_node];
        cap_on = 1;
      end
      r.fired = 1'b1;
      r.handler_node = cap_node;
      r.out_control = cap_c;
      r.out_data = cap_d;
      pending = 1;
    end
    r.delta_x = dx;
    r.delta_y = dy;
    if (!c.touch_down) begin
      cap_node = '0; cap_on = 0; cap_c = '0; cap_d = '0;
    end
  endfunction

  function automatic void clip_rect(input snh_pkg::in_t c, inout snh_pkg::out_t r);
    int l, t, rr, b;
    logic [7:0] id;
    id = c.node_id;
    l = imax(org_x[id] + s16(int'(c.pos_x)), 0) & 32'hFFFF;
    t = imax(org_y[id] + s16(int'(c.pos_y)), 0) & 32'hFFFF;
    rr = (l + int'(c.width)) & 32'hFFFF;
    b = (t + int'(c.height)) & 32'hFFFF;
    r.clip_left = 16'(imax(l, clp_l[id]));
    r.clip_top = 16'(imax(t, clp_t[id]));
    r.clip_right = 16'(imin(rr, clp_r[id]));
    r.clip_bottom = 16'(imin(b, clp_b[id]));
  endfunction

  function automatic bit predict_result(input snh_pkg::in_t c, output snh_pkg::out_t r);
    r = '0;
    case (c.kind)
      snh_pkg::KIND_CREATE: r.new_node_id = create_node(c);
      snh_pkg::KIND_TOUCH: touch_event(c, r);
      snh_pkg::KIND_CLIP: begin
        if (c.node_id == 0) return 0;
        clip_rect(c, r);
      end
      default: begin
        r.pending_flag = pending;
        pending = 0;
      end
    endcase
    return 1;
  endfunction

  function automatic snh_pkg::in_t noise_cmd();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(snh_pkg::in_t)-1:0];
  endfunction

  function automatic snh_pkg::in_t create_cmd(input logic [7:0] p, input int x, input int y,
                                              input int w, input int h, input bit hh);
    snh_pkg::in_t c;
    c = noise_cmd();
    c.kind = snh_pkg::KIND_CREATE;
    c.node_id = p;
    c.pos_x = 16'(x); c.pos_y = 16'(y);
    c.width = 16'(w); c.height = 16'(h);
    c.has_handler = hh;
    return c;
  endfunction

  function automatic snh_pkg::in_t touch_cmd(input bit down, input int x, input int y);
    snh_pkg::in_t c;
    c = noise_cmd();
    c.kind = snh_pkg::KIND_TOUCH;
    c.touch_down = down;
    c.touch_x = 16'(x); c.touch_y = 16'(y);
    return c;
  endfunction

  function automatic snh_pkg::in_t clip_cmd(input logic [7:0] id, input int x, input int y,
                                            input int w, input int h);
    snh_pkg::in_t c;
    c = create_cmd(id, x, y, w, h, 0);
    c.kind = snh_pkg::KIND_CLIP;
    return c;
  endfunction

  function automatic snh_pkg::in_t query_cmd();
    snh_pkg::in_t c;
    c = noise_cmd();
    c.kind = snh_pkg::KIND_QUERY;
    return c;
  endfunction

  function automatic logic [7:0] pick_node();
    int hi;
    hi = (next_id == 0) ? 255 : int'(next_id) - 1;
    if (hi < 1 || $urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(1, hi));
  endfunction

  task automatic send_cmd(input snh_pkg::in_t c);
    int gap;
    snh_pkg::out_t r;
    gap = in_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    if (predict_result(c, r)) result_q.push_back(r);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (result_q.size() != 0);
  endtask

  task automatic test_directed();
    send_cmd(query_cmd());
    send_cmd(touch_cmd(1, 0, 0));
    send_cmd(clip_cmd(8'd0, 5, 5, 10, 10));
    send_cmd(clip_cmd(8'd5, -32768, 32767, 65535, 65535));
    send_cmd(create_cmd(8'd7, 0, 0, 0, 0, 1));
    send_cmd(create_cmd(8'd0, -32768, -32768, 65535, 65535, 0));
    send_cmd(create_cmd(8'd0, 32767, 32767, 0, 0, 1));
    send_cmd(create_cmd(8'd0, 100, 100, 300, 300, 1));
    send_cmd(create_cmd(8'd1, 10, 10, 100, 100, 0));
    send_cmd(create_cmd(8'd2, 5, 5, 20, 20, 0));
    send_cmd(create_cmd(8'd2, 5000, 5000, 10, 10, 1));
    send_cmd(touch_cmd(1, 120, 120));
    send_cmd(touch_cmd(1, 130, 115));
    send_cmd(touch_cmd(1, 5, 5));
    send_cmd(touch_cmd(0, 5, 5));
    send_cmd(query_cmd());
    send_cmd(query_cmd());
    send_cmd(touch_cmd(1, 40000, 120));
    send_cmd(touch_cmd(0, 65535, 65535));
    send_cmd(clip_cmd(8'd3, -50, 3, 65535, 7));
    send_cmd(clip_cmd(8'd255, 0, 0, 65535, 65535));
    send_cmd(create_cmd(8'd3, -32768, 32767, 65535, 65535, 1));
  endtask

  task automatic test_backpressure();
    hold_req = 300;
    in_burst = 1;
    repeat (30) send_cmd($urandom_range(0, 1) ? query_cmd() : clip_cmd(pick_node(), 0, 0, 9, 9));
    in_burst = 0;
    wait_drained();
  endtask

  task automatic test_id_exhaustion();
    send_cmd(create_cmd(8'd0, 0, 0, 32000, 32000, 1));
    repeat (256) send_cmd(create_cmd(8'($urandom_range(1, 2)), $urandom_range(0, 300),
                                     $urandom_range(0, 300), $urandom_range(0, 200),
                                     $urandom_range(0, 200), $urandom_range(0, 1)));
    send_cmd(touch_cmd(1, 150, 150));
    send_cmd(touch_cmd(0, 150, 150));
    send_cmd(query_cmd());
  endtask

  task automatic test_random();
    int sel, steps, x, y;
    logic [7:0] n;
    while (sent < 650) begin
      if ($urandom_range(0, 40) == 0) in_burst = ~in_burst;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        send_cmd(noise_cmd());
      end else if (sel < 12) begin
        send_cmd(create_cmd(8'd0, $urandom_range(0, 2000), $urandom_range(0, 2000),
                            $urandom_range(0, 3000), $urandom_range(0, 3000),
                            $urandom_range(0, 1)));
      end else if (sel < 40) begin
        if ($urandom_range(0, 9) == 0)
          send_cmd(create_cmd(pick_node(), $urandom, $urandom, $urandom, $urandom,
                              $urandom_range(0, 1)));
        else
          send_cmd(create_cmd(pick_node(), $urandom_range(0, 150), $urandom_range(0, 150),
                              $urandom_range(0, 300), $urandom_range(0, 300),
                              $urandom_range(0, 1)));
      end else if (sel < 65) begin
        steps = $urandom_range(1, 4);
        repeat (steps) begin
          n = pick_node();
          x = (clp_r[n] >= clp_l[n]) ? $urandom_range(clp_l[n], clp_r[n]) : $urandom_range(0, 65535);
          y = (clp_b[n] >= clp_t[n]) ? $urandom_range(clp_t[n], clp_b[n]) : $urandom_range(0, 65535);
          send_cmd(touch_cmd(1, x, y));
        end
        if ($urandom_range(0, 4) != 0) send_cmd(touch_cmd(0, $urandom, $urandom));
      end else if (sel < 82) begin
        if ($urandom_range(0, 4) == 0)
          send_cmd(clip_cmd(pick_node(), $urandom, $urandom, $urandom, $urandom));
        else
          send_cmd(clip_cmd(pick_node(), $urandom_range(0, 200), $urandom_range(0, 200),
                            $urandom_range(0, 400), $urandom_range(0, 400)));
      end else begin
        send_cmd(query_cmd());
      end
    end
  endtask

  // result side
  initial begin
    int n;
    snh_pkg::out_t e;
    @(posedge rst_ni);
    forever begin
      if (hold_req > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_req) @(posedge clk_i);
        hold_req = 0;
      end
      if ($urandom_range(0, 40) == 0) out_burst = ~out_burst;
      n = out_burst ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      forever begin
        @(posedge clk_i);
        if (out_valid_o && !out_stall_i) begin
          if (result_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %p", out_data_o);
          end else begin
            e = result_q.pop_front();
            if (out_data_o !== e) begin
              mismatches++;
              if (mismatches <= 10) $display("mismatch exp %p act %p", e, out_data_o);
            end
          end
          break;
        end
        if (hold_req > 0) break;
      end
    end
  end

  // watchdog on cycles with no accepted beat
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 256; i++) begin
      org_x[i] = 0; org_y[i] = 0;
      clp_l[i] = 0; clp_t[i] = 0; clp_r[i] = 0; clp_b[i] = 0;
      hnd_v[i] = 0; hnd_c[i] = '0; hnd_d[i] = '0; par_id[i] = '0;
    end
    next_id = 8'd1;
    last_x = '0; last_y = '0;
    cap_node = '0; cap_on = 0; cap_c = '0; cap_d = '0;
    pending = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_id_exhaustion();
    test_random();
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
